FILE: rtl/core/mvt_pkg.sv
// mvt_pkg: shared types and constants of the matrix vector transform
`timescale 1ns / 1ps
`default_nettype none
package mvt_pkg;

	// fixed-point word and item widths
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned CFG_W    = 64;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned DIM      = 4;

	// register indexes of the matrix rows
	typedef enum logic [IDX_W-1:0] {
		REG_ROW0_COLS01 = 3'd0,
		REG_ROW0_COLS23 = 3'd1,
		REG_ROW1_COLS01 = 3'd2,
		REG_ROW1_COLS23 = 3'd3,
		REG_ROW2_COLS01 = 3'd4,
		REG_ROW2_COLS23 = 3'd5,
		REG_ROW3_COLS01 = 3'd6,
		REG_ROW3_COLS23 = 3'd7
	} reg_idx_t;

	typedef logic [DIM-1:0][DATA_W-1:0] vec4_t;
	typedef logic [DIM-1:0][DIM-1:0][DATA_W-1:0] mat4_t;

	// load enables of the five pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage
`default_nettype wire

FILE: rtl/core/mvt_cfg_regs.sv
// mvt_cfg_regs: matrix configuration registers, two entries per register
`timescale 1ns / 1ps
`default_nettype none
module mvt_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [mvt_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [mvt_pkg::CFG_W-1:0]   wr_data,
	output mvt_pkg::mat4_t                   matrix
);

	logic [mvt_pkg::NUM_REGS-1:0][mvt_pkg::CFG_W-1:0] regs_q;

	// register writes, every index of the port maps to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_en) begin
			regs_q[wr_index] <= wr_data;
		end
	end

	// unpack entries: low half even column, high half odd column
	always_comb begin
		for (int r = 0; r < mvt_pkg::DIM; r++) begin
			for (int c = 0; c < mvt_pkg::DIM; c++) begin
				matrix[r][c] = (c % 2 == 1) ?
					regs_q[r * 2 + c / 2][mvt_pkg::CFG_W-1:mvt_pkg::DATA_W] :
					regs_q[r * 2 + c / 2][mvt_pkg::DATA_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/mvt_row.sv
// mvt_row: one matrix row dot product, five register stages
`timescale 1ns / 1ps
`default_nettype none
module mvt_row #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire mvt_pkg::stage_en_t          en,
	input  wire mvt_pkg::vec4_t              vec,
	input  wire mvt_pkg::vec4_t              row,
	output logic [mvt_pkg::DATA_W-1:0]       res,
	output logic                             sat
);

	localparam int unsigned PROD_W = 2 * mvt_pkg::DATA_W;
	localparam int unsigned PAIR_W = PROD_W + 1;
	localparam int unsigned SUM_W  = PROD_W + 2;
	localparam int unsigned MAG_W  = PROD_W + 1;
	localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'({1'b0, {(mvt_pkg::DATA_W-1){1'b1}}});
	localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'({1'b1, {(mvt_pkg::DATA_W-1){1'b0}}});
	localparam logic [mvt_pkg::DATA_W-1:0] POS_SAT = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
	localparam logic [mvt_pkg::DATA_W-1:0] NEG_SAT = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1 [mvt_pkg::DIM];
	logic signed [PAIR_W-1:0] pair0_s2, pair1_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     neg_s4;
	logic [MAG_W-1:0]         mag_s4;
	logic [MAG_W-1:0]         shifted;

	// stage 1: four exact signed products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int j = 0; j < mvt_pkg::DIM; j++) begin
				prod_s1[j] <= $signed(row[j]) * $signed(vec[j]);
			end
		end
	end

	// stage 2: pairwise sums
	always_ff @(posedge clk) begin
		if (en.s2) begin
			pair0_s2 <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
			pair1_s2 <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
		end
	end

	// stage 3: full-width row sum
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum_s3 <= SUM_W'(pair0_s2) + SUM_W'(pair1_s2);
		end
	end

	// stage 4: sign and magnitude
	always_ff @(posedge clk) begin
		if (en.s4) begin
			neg_s4 <= sum_s3[SUM_W-1];
			mag_s4 <= sum_s3[SUM_W-1] ? MAG_W'(-sum_s3) : MAG_W'(sum_s3);
		end
	end

	// magnitude truncated toward zero
	assign shifted = mag_s4 >> FRAC_BITS;

	// stage 5: restore sign and saturate
	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (mag_s4[MAG_W-1]) begin
				sat <= 1'b1;
				res <= neg_s4 ? NEG_SAT : POS_SAT;
			end else if (neg_s4) begin
				sat <= (shifted > NEG_LIMIT);
				res <= (shifted > NEG_LIMIT) ? NEG_SAT :
					(~shifted[mvt_pkg::DATA_W-1:0]) + mvt_pkg::DATA_W'(1);
			end else begin
				sat <= (shifted > POS_LIMIT);
				res <= (shifted > POS_LIMIT) ? POS_SAT : shifted[mvt_pkg::DATA_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/matrix_vector_transform.sv
// matrix_vector_transform: top level of the pipelined 4x4 matrix vector transform
//
// channel  direction  handshake                 payload
// in       input      in_valid / in_ready       in_x, in_y, in_z, in_w
// out      output     out_valid / out_ready     out_x, out_y, out_z, out_w, saturated
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high; out_valid rises when the item reaches the last stage
// the item passes through the multiply, two adder levels, sign and magnitude, and saturate stages
// stages advance independently, so bubbles close up and in_ready stays high while
// the output register waits, until the whole pipeline is full
// reset clears all stage valid bits and the matrix to zero; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none
module matrix_vector_transform #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [mvt_pkg::DATA_W-1:0] in_x,
	input  wire logic signed [mvt_pkg::DATA_W-1:0] in_y,
	input  wire logic signed [mvt_pkg::DATA_W-1:0] in_z,
	input  wire logic signed [mvt_pkg::DATA_W-1:0] in_w,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [mvt_pkg::DATA_W-1:0]      out_x,
	output logic signed [mvt_pkg::DATA_W-1:0]      out_y,
	output logic signed [mvt_pkg::DATA_W-1:0]      out_z,
	output logic signed [mvt_pkg::DATA_W-1:0]      out_w,
	output logic                                   saturated,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mvt_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [mvt_pkg::CFG_W-1:0]         cfg_data
);

	localparam logic [mvt_pkg::DATA_W-1:0] OUT_MAX = {1'b0, {(mvt_pkg::DATA_W-1){1'b1}}};
	localparam logic [mvt_pkg::DATA_W-1:0] OUT_MIN = {1'b1, {(mvt_pkg::DATA_W-1){1'b0}}};

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	mvt_pkg::stage_en_t en;
	mvt_pkg::mat4_t     matrix;
	mvt_pkg::vec4_t     vec;
	logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] res;
	logic [mvt_pkg::DIM-1:0] sat;

	assign cfg_ready = 1'b1;

	// matrix registers
	mvt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.matrix   (matrix)
	);

	// per-stage ready: a stage loads when empty or when its successor loads
	always_comb begin
		en.s5 = !v_s5 || out_ready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s5;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	assign vec = {in_w, in_z, in_y, in_x};

	// one dot-product pipeline per matrix row
	for (genvar r = 0; r < mvt_pkg::DIM; r++) begin : g_row
		mvt_row #(
			.FRAC_BITS (FRAC_BITS)
		) u_row (
			.clk (clk),
			.en  (en),
			.vec (vec),
			.row (matrix[r]),
			.res (res[r]),
			.sat (sat[r])
		);
	end

	assign out_x     = res[0];
	assign out_y     = res[1];
	assign out_z     = res[2];
	assign out_w     = res[3];
	assign saturated = |sat;

	// an empty or draining output stage lets the whole chain take an item
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s5 || out_ready) |-> in_ready)
		else $error("in_ready low with a free output stage");

	// a stalled middle stage keeps its item
	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en.s3) |=> v_s3)
		else $error("stalled stage lost its item");

	// a flagged result carries at least one clamped component
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(out_x == OUT_MAX || out_x == OUT_MIN || out_y == OUT_MAX || out_y == OUT_MIN ||
		 out_z == OUT_MAX || out_z == OUT_MIN || out_w == OUT_MAX || out_w == OUT_MIN))
		else $error("saturated set without a clamped component");

endmodule
`default_nettype wire

FILE: bench/mvt_checker.sv
// mvt_checker: predicts each transform result and compares it with what the block returns
`timescale 1ns / 1ps
module mvt_checker #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [mvt_pkg::DATA_W-1:0] in_x,
	input  logic [mvt_pkg::DATA_W-1:0] in_y,
	input  logic [mvt_pkg::DATA_W-1:0] in_z,
	input  logic [mvt_pkg::DATA_W-1:0] in_w,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [mvt_pkg::DATA_W-1:0] out_x,
	input  logic [mvt_pkg::DATA_W-1:0] out_y,
	input  logic [mvt_pkg::DATA_W-1:0] out_z,
	input  logic [mvt_pkg::DATA_W-1:0] out_w,
	input  logic                       saturated,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [mvt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [mvt_pkg::CFG_W-1:0]  cfg_data,
	output int                         fails,
	output int                         pending,
	output int                         results_seen,
	output int                         clamped_seen
);

	// one transformed vector plus its clamp flag
	typedef struct packed {
		mvt_pkg::vec4_t vec;
		logic           sat;
	} xform_t;

	mvt_pkg::mat4_t matrix = '0;
	xform_t         expected_xforms[$];
	string          comp_name[mvt_pkg::DIM] = '{"x", "y", "z", "w"};

	initial begin
		fails        = 0;
		pending      = 0;
		results_seen = 0;
		clamped_seen = 0;
	end

	// exact row sums, truncation toward zero, then clamp to 32 bits
	function automatic xform_t transform(input mvt_pkg::mat4_t m, input mvt_pkg::vec4_t v);
		xform_t             res;
		logic signed [79:0] acc;
		logic [79:0]        mag;
		logic [79:0]        quot;
		logic               neg;
		res = '0;
		for (int r = 0; r < mvt_pkg::DIM; r++) begin
			acc = '0;
			for (int c = 0; c < mvt_pkg::DIM; c++) begin
				acc = acc + $signed(m[r][c]) * $signed(v[c]);
			end
			neg  = acc[79];
			mag  = neg ? -acc : acc;
			quot = mag >> FRAC_BITS;
			if (neg) begin
				if (quot > 80'h8000_0000) begin
					res.sat    = 1'b1;
					res.vec[r] = 32'h8000_0000;
				end else begin
					res.vec[r] = ~quot[31:0] + 32'd1;
				end
			end else if (quot > 80'h7FFF_FFFF) begin
				res.sat    = 1'b1;
				res.vec[r] = 32'h7FFF_FFFF;
			end else begin
				res.vec[r] = quot[31:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fails++;
	endtask

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin : monitor
		int     row;
		int     col;
		xform_t got;
		xform_t want;
		if (!arst_n) begin
			matrix = '0;
			expected_xforms.delete();
			pending = 0;
		end else begin
			// matrix register write: low half even column, high half odd column
			if (cfg_valid && cfg_ready) begin
				row = int'(cfg_index) >> 1;
				col = (int'(cfg_index) & 1) * 2;
				matrix[row][col]     = cfg_data[31:0];
				matrix[row][col + 1] = cfg_data[63:32];
			end
			// accepted vector
			if (in_valid && in_ready) begin
				expected_xforms.push_back(transform(matrix, {in_w, in_z, in_y, in_x}));
			end
			// returned result against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_xforms.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no vector pending",
						results_seen));
				end else begin
					want     = expected_xforms.pop_front();
					got.vec  = {out_w, out_z, out_y, out_x};
					got.sat  = saturated;
					for (int i = 0; i < mvt_pkg::DIM; i++) begin
						if (got.vec[i] !== want.vec[i]) begin
							report_mismatch($sformatf("result %0d out_%s: got %h expected %h",
								results_seen, comp_name[i], got.vec[i], want.vec[i]));
						end
					end
					if (got.sat !== want.sat) begin
						report_mismatch($sformatf("result %0d saturated: got %b expected %b",
							results_seen, got.sat, want.sat));
					end
					if (want.sat) begin
						clamped_seen++;
					end
				end
				results_seen++;
			end
			pending = expected_xforms.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// tb_top: clock, reset, stimulus and verdict for the matrix vector transform
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned FRAC_BITS     = 16;
	localparam int unsigned CLK_PERIOD    = 10;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD     = 60;
	localparam int unsigned RANDOM_PHASES = 7;
	localparam int unsigned PHASE_ITEMS   = 86;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam logic [31:0] ONE           = 32'd1 << FRAC_BITS;
	localparam logic [31:0] MAX_W         = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_W         = 32'h8000_0000;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [mvt_pkg::DATA_W-1:0] in_x;
	logic [mvt_pkg::DATA_W-1:0] in_y;
	logic [mvt_pkg::DATA_W-1:0] in_z;
	logic [mvt_pkg::DATA_W-1:0] in_w;
	logic                       out_valid;
	logic                       out_ready;
	logic [mvt_pkg::DATA_W-1:0] out_x;
	logic [mvt_pkg::DATA_W-1:0] out_y;
	logic [mvt_pkg::DATA_W-1:0] out_z;
	logic [mvt_pkg::DATA_W-1:0] out_w;
	logic                       saturated;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [mvt_pkg::IDX_W-1:0]  cfg_index;
	logic [mvt_pkg::CFG_W-1:0]  cfg_data;

	int fails;
	int pending;
	int results_seen;
	int clamped_seen;
	int vectors_sent  = 0;
	int settings_used = 0;
	int idle_cycles   = 0;
	bit gaps_on       = 1'b1;
	bit stalls_on     = 1'b1;
	bit hold_req      = 1'b0;

	matrix_vector_transform #(.FRAC_BITS(FRAC_BITS)) u_dut (.*);

	mvt_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

	// clock
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog on cycles where no item moves on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// writes all eight matrix registers back to back
	task automatic load_matrix(input mvt_pkg::mat4_t m);
		for (int i = 0; i < mvt_pkg::NUM_REGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= mvt_pkg::reg_idx_t'(i);
			cfg_data  <= {m[i / 2][(i % 2) * 2 + 1], m[i / 2][(i % 2) * 2]};
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// offers one vector, sometimes after an idle burst
	task automatic send_vec(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [31:0] w);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_x     <= x;
		in_y     <= y;
		in_z     <= z;
		in_w     <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		vectors_sent++;
	endtask

	// waits until every accepted vector has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return MAX_W;
			1: return MIN_W;
			2: return 32'h0;
			3: return ONE;
			4: return -ONE;
			5: return 32'hFFFF_FFFF;
			default: return 32'h1;
		endcase
	endfunction

	// 0: within +-8.0, 1: full range, 2: corner values, else a mix per word
	function automatic logic [31:0] rand_word(input int kind);
		case (kind)
			0: return $urandom_range(0, 16 * ONE) - 8 * ONE;
			1: return $urandom;
			2: return pick_extreme();
			default: return rand_word($urandom_range(0, 2));
		endcase
	endfunction

	function automatic mvt_pkg::mat4_t random_matrix(input int kind);
		mvt_pkg::mat4_t m;
		for (int r = 0; r < mvt_pkg::DIM; r++) begin
			for (int c = 0; c < mvt_pkg::DIM; c++) begin
				m[r][c] = rand_word(kind);
			end
		end
		return m;
	endfunction

	// main sequence
	initial begin
		mvt_pkg::mat4_t mat;
		int             vk;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_x      = '0;
		in_y      = '0;
		in_z      = '0;
		in_w      = '0;
		cfg_valid = 1'b0;
		cfg_index = mvt_pkg::REG_ROW0_COLS01;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// matrix is zero out of reset
		send_vec(MAX_W, MAX_W, MAX_W, MAX_W);
		send_vec(MIN_W, MIN_W, MIN_W, MIN_W);

		// rows: copy x, double x, half x minus half y, extreme entries
		wait_drained();
		mat       = '0;
		mat[0][0] = ONE;
		mat[1][0] = 2 * ONE;
		mat[2][0] = ONE >> 1;
		mat[2][1] = -(ONE >> 1);
		mat[3]    = {MIN_W, MAX_W, MIN_W, MAX_W};
		load_matrix(mat);
		send_vec(32'h0, 32'h0, 32'h0, 32'h0);
		// negative halves truncate toward zero
		send_vec(32'h1, 32'h0, 32'h0, 32'h0);
		send_vec(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
		send_vec(32'hFFFF_FFFD, 32'h0, 32'h0, 32'h0);
		// doubling right at the clamp edges, exact minimum is not clamped
		send_vec(32'h4000_0000, 32'h0, 32'h0, 32'h0);
		send_vec(32'hC000_0000, 32'h0, 32'h0, 32'h0);
		send_vec(32'hBFFF_FFFF, 32'h0, 32'h0, 32'h0);
		send_vec(32'h3FFF_FFFF, 32'h0, 32'h0, 32'h0);
		send_vec(MIN_W, 32'h0, 32'h0, 32'h0);
		send_vec(MAX_W, MAX_W, MAX_W, MAX_W);
		send_vec(MIN_W, MIN_W, MIN_W, MIN_W);
		send_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		send_vec(32'h5555_5555, 32'hAAAA_AAAA, ONE, -ONE);

		// every entry at the most negative value
		wait_drained();
		mat = {16{MIN_W}};
		load_matrix(mat);
		send_vec(MIN_W, MIN_W, MIN_W, MIN_W);
		send_vec(MAX_W, MAX_W, MAX_W, MAX_W);
		send_vec(MAX_W, MIN_W, MAX_W, MIN_W);

		// every entry at the most positive value
		wait_drained();
		mat = {16{MAX_W}};
		load_matrix(mat);
		send_vec(MAX_W, MAX_W, MAX_W, MAX_W);
		send_vec(MIN_W, MIN_W, MIN_W, MIN_W);
		send_vec(32'h0, 32'h0, 32'h0, 32'h0);

		// random matrices and vectors; long output hold in one phase, no idling in the last
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			load_matrix(random_matrix(p % 4));
			if (p == 1) begin
				hold_req = 1'b1;
			end
			if (p == RANDOM_PHASES - 1) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				vk = $urandom_range(0, 3);
				send_vec(rand_word(vk), rand_word(vk), rand_word(vk), rand_word(vk));
			end
		end

		// let the pipeline empty, then watch for strays
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("covered %0d vectors under %0d matrix loads plus the reset matrix",
			vectors_sent, settings_used);
		$display("%0d results checked, %0d clamped, one long output hold to back up the pipe",
			results_seen, clamped_seen);
		if (fails == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
